[rtl/mesh_tangent_accumulator_core_macros.svh]
// Assertion macros shared by the tangent accumulator checker.
`ifndef MESH_TANGENT_ACCUMULATOR_CORE_MACROS_SVH
`define MESH_TANGENT_ACCUMULATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MTA_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("mtacc check failed");

// Next-cycle implication, disabled while reset is low.
`define MTA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("mtacc check failed");

`endif

[rtl/mtacc_pkg.sv]
// Types, codes and constants of the mesh tangent accumulator.
`timescale 1ns / 1ps
package mtacc_pkg;

  localparam int unsigned IDX_W   = 10;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned TAN_W   = 16;
  // Wide enough for a raw tangent (35 bits signed) and any sum (up to 32 bits).
  localparam int unsigned VEC_W   = 36;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TRI  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  // Address source for the vertex and sum memories.
  typedef enum logic [1:0] {
    SEL_A   = 2'd0,
    SEL_B   = 2'd1,
    SEL_C   = 2'd2,
    SEL_IDX = 2'd3
  } sel_e;

  typedef struct packed {
    logic [1:0]                operation;
    logic [IDX_W-1:0]          vertex_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] tex_u;
    logic signed [COORD_W-1:0] tex_v;
    logic [IDX_W-1:0]          corner_a;
    logic [IDX_W-1:0]          corner_b;
    logic [IDX_W-1:0]          corner_c;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]        read_index;
    logic signed [TAN_W-1:0] tangent_x;
    logic signed [TAN_W-1:0] tangent_y;
    logic signed [TAN_W-1:0] tangent_z;
    logic                    zero_length;
  } out_beat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic signed [COORD_W-1:0] u;
    logic signed [COORD_W-1:0] v;
  } vtx_t;

  typedef struct packed {
    logic capture;
    logic vtx_load;
    logic vrd;
    sel_e vrd_sel;
    logic vcap;
    sel_e vcap_sel;
    logic mul_start;
    logic norm_start;
    logic norm_src_sum;
    logic sum_rd;
    logic sum_wr;
    sel_e sum_sel;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic idx_ok;
    logic corners_ok;
    logic mul_done;
    logic det_zero;
    logic norm_done;
    logic norm_zero;
    logic out_free;
  } status_t;

endpackage

[rtl/mtacc_norm.sv]
// Iterative vector normalizer: scale, sum of squares, root and divide to Q1.14.
`timescale 1ns / 1ps
module mtacc_norm (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [mtacc_pkg::VEC_W-1:0]   vec_i [3],
  output logic                                 done_o,
  output logic                                 zero_o,
  output logic signed [mtacc_pkg::TAN_W-1:0]   n_o [3]
);
  import mtacc_pkg::*;

  localparam int unsigned LEN_W = 62;
  localparam int unsigned ROOT_W = 31;
  localparam int unsigned REM_W = 45;
  localparam int unsigned QUO_W = 15;
  localparam logic [QUO_W-1:0] Q_ONE = 15'd16384;

  typedef enum logic [6:0] {
    N_IDLE  = 7'b0000001,
    N_SHIFT = 7'b0000010,
    N_SQ    = 7'b0000100,
    N_SQRT  = 7'b0001000,
    N_DINIT = 7'b0010000,
    N_DIV   = 7'b0100000,
    N_DONE  = 7'b1000000
  } nstate_e;

  nstate_e state_q, state_d;
  logic [VEC_W-1:0] mag_q [3];
  logic             neg_q [3];
  logic [VEC_W-1:0] m;
  logic [1:0]       cnt_q;
  logic [59:0]      sq_q;
  logic [LEN_W-1:0] x_q, res_q, bit_q, trial;
  logic [REM_W-1:0] rem_q, dvs;
  logic [QUO_W-1:0] quo_q, quo_d, q_clamp;
  logic [3:0]       qb_q;
  logic             zero_q;
  logic [ROOT_W-1:0] r;
  logic             ge;

  // Largest magnitude of the three components
  always_comb begin
    m = mag_q[0];
    if (mag_q[1] > m) m = mag_q[1];
    if (mag_q[2] > m) m = mag_q[2];
  end

  assign trial = res_q + bit_q;
  assign r     = res_q[ROOT_W-1:0];
  assign dvs   = REM_W'(r) << qb_q;
  assign ge    = (rem_q >= dvs);
  assign quo_d = ge ? (quo_q | (QUO_W'(1) << qb_q)) : quo_q;
  assign q_clamp = (quo_d > Q_ONE) ? Q_ONE : quo_d;

  // Step sequence
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      N_IDLE:  if (start_i) state_d = N_SHIFT;
      N_SHIFT: begin
        if (m == '0) state_d = N_DONE;
        else if (m < (VEC_W'(1) << 30) && m >= (VEC_W'(1) << 29)) state_d = N_SQ;
      end
      N_SQ:    if (cnt_q == 2'd3) state_d = N_SQRT;
      N_SQRT:  if (bit_q[0]) state_d = N_DINIT;
      N_DINIT: state_d = N_DIV;
      N_DIV: begin
        if (qb_q == '0) state_d = (cnt_q == 2'd2) ? N_DONE : N_DINIT;
      end
      N_DONE:  state_d = N_IDLE;
      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      cnt_q   <= '0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == N_IDLE && start_i) begin
        cnt_q  <= '0;
        zero_q <= 1'b0;
      end
      if (state_q == N_SHIFT && m == '0) zero_q <= 1'b1;
      if (state_q == N_SQ) cnt_q <= cnt_q + 2'd1;
      if (state_q == N_SQRT) cnt_q <= '0;
      if (state_q == N_DIV && qb_q == '0) cnt_q <= cnt_q + 2'd1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      N_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            neg_q[i] <= vec_i[i][VEC_W-1];
            mag_q[i] <= vec_i[i][VEC_W-1] ? VEC_W'(-vec_i[i]) : VEC_W'(vec_i[i]);
          end
        end
      end
      N_SHIFT: begin
        // move the largest magnitude into [2^29, 2^30), one bit a cycle
        if (m >= (VEC_W'(1) << 30)) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
        end else if (m < (VEC_W'(1) << 29)) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
        end
      end
      N_SQ: begin
        // square one component a cycle, add the previous square
        if (cnt_q != 2'd3) sq_q <= mag_q[cnt_q][29:0] * mag_q[cnt_q][29:0];
        if (cnt_q == 2'd0) x_q <= '0;
        else x_q <= x_q + LEN_W'(sq_q);
        res_q <= '0;
        bit_q <= LEN_W'(1) << 60;
      end
      N_SQRT: begin
        // one root digit a cycle
        if (x_q >= trial) begin
          x_q   <= x_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      N_DINIT: begin
        rem_q <= REM_W'({mag_q[cnt_q][29:0], 14'b0}) + REM_W'(r >> 1);
        quo_q <= '0;
        qb_q  <= 4'd14;
      end
      N_DIV: begin
        // one quotient bit a cycle
        if (ge) rem_q <= rem_q - dvs;
        quo_q <= quo_d;
        qb_q  <= qb_q - 4'd1;
        if (qb_q == '0) begin
          n_o[cnt_q] <= neg_q[cnt_q] ? -TAN_W'(q_clamp) : TAN_W'(q_clamp);
        end
      end
      N_DONE: ;
      default: ;
    endcase
  end

  assign done_o = (state_q == N_DONE);
  assign zero_o = zero_q;

endmodule

[rtl/mtacc_datapath.sv]
// Datapath: vertex and sum memories, delta multiplier, normalizer, output register.
`timescale 1ns / 1ps
module mtacc_datapath #(
  parameter int unsigned VERTEX_SLOTS = 1024,
  parameter int unsigned SUM_WIDTH    = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mtacc_pkg::in_beat_t   in_beat_i,
  input  mtacc_pkg::cmd_t       cmd_i,
  output mtacc_pkg::status_t    sts_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output mtacc_pkg::out_beat_t  out_beat_o
);
  import mtacc_pkg::*;

  localparam int unsigned AW = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;
  localparam int unsigned SW = SUM_WIDTH;
  localparam logic signed [SW:0] SUM_MAX = {2'b00, {(SW-1){1'b1}}};
  localparam logic signed [SW:0] SUM_MIN = {2'b11, {(SW-1){1'b0}}};

  in_beat_t beat_q;
  vtx_t     vmem [VERTEX_SLOTS];
  logic [3*SW-1:0] smem [VERTEX_SLOTS];
  vtx_t     vrdata_q, v0_q, v1_q, v2_q;
  logic [3*SW-1:0] srdata_q, swdata;
  logic [AW-1:0] vraddr, saddr, swaddr;

  function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
    return AW'(idx);
  endfunction

  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    return 32'(idx) < VERTEX_SLOTS;
  endfunction

  function automatic logic [IDX_W-1:0] sel_idx(input in_beat_t b, input sel_e s);
    logic [IDX_W-1:0] idx;
    case (s)
      SEL_A:   idx = b.corner_a;
      SEL_B:   idx = b.corner_b;
      SEL_C:   idx = b.corner_c;
      default: idx = b.vertex_index;
    endcase
    return idx;
  endfunction

  function automatic logic signed [16:0] dlt(input logic signed [15:0] a,
                                             input logic signed [15:0] b);
    return 17'(a) - 17'(b);
  endfunction

  // Hold the accepted beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) beat_q <= in_beat_i;
  end

  assign vraddr = to_addr(sel_idx(beat_q, cmd_i.vrd_sel));
  assign saddr  = to_addr(sel_idx(beat_q, cmd_i.sum_sel));
  assign swaddr = cmd_i.vtx_load ? to_addr(beat_q.vertex_index) : saddr;

  // Vertex memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.vtx_load) begin
      vmem[to_addr(beat_q.vertex_index)] <= '{px: beat_q.pos_x, py: beat_q.pos_y,
                                             pz: beat_q.pos_z, u: beat_q.tex_u,
                                             v: beat_q.tex_v};
    end
    if (cmd_i.vrd) vrdata_q <= vmem[vraddr];
  end

  // Sum memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.vtx_load || cmd_i.sum_wr) smem[swaddr] <= cmd_i.vtx_load ? '0 : swdata;
    if (cmd_i.sum_rd) srdata_q <= smem[saddr];
  end

  // Capture the corners
  always_ff @(posedge clk_i) begin
    if (cmd_i.vcap) begin
      case (cmd_i.vcap_sel)
        SEL_A:   v0_q <= vrdata_q;
        SEL_B:   v1_q <= vrdata_q;
        default: v2_q <= vrdata_q;
      endcase
    end
  end

  // Edge and UV deltas
  logic signed [16:0] e1x, e1y, e1z, e2x, e2y, e2z, d1u, d1v, d2u, d2v;
  assign e1x = dlt(v1_q.px, v0_q.px);
  assign e1y = dlt(v1_q.py, v0_q.py);
  assign e1z = dlt(v1_q.pz, v0_q.pz);
  assign e2x = dlt(v2_q.px, v0_q.px);
  assign e2y = dlt(v2_q.py, v0_q.py);
  assign e2z = dlt(v2_q.pz, v0_q.pz);
  assign d1u = dlt(v1_q.u, v0_q.u);
  assign d1v = dlt(v1_q.v, v0_q.v);
  assign d2u = dlt(v2_q.u, v0_q.u);
  assign d2v = dlt(v2_q.v, v0_q.v);

  // Shared multiplier: eight products, paired into det and three tangent terms
  logic [3:0]         mcnt_q, mcnt_m1;
  logic               mbusy_q, mdone_q;
  logic signed [16:0] opa, opb;
  logic signed [33:0] prod_q, hold_q;
  logic signed [34:0] det_q, diff;
  logic signed [34:0] t_q [3];

  always_comb begin
    case (mcnt_q[2:0])
      3'd0:    begin opa = d1u; opb = d2v; end
      3'd1:    begin opa = d2u; opb = d1v; end
      3'd2:    begin opa = d2v; opb = e1x; end
      3'd3:    begin opa = d1v; opb = e2x; end
      3'd4:    begin opa = d2v; opb = e1y; end
      3'd5:    begin opa = d1v; opb = e2y; end
      3'd6:    begin opa = d2v; opb = e1z; end
      default: begin opa = d1v; opb = e2z; end
    endcase
  end

  assign mcnt_m1 = mcnt_q - 4'd1;
  assign diff    = 35'(hold_q) - 35'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      mcnt_q  <= '0;
      mdone_q <= 1'b0;
    end else begin
      mdone_q <= mbusy_q && (mcnt_q == 4'd8);
      if (cmd_i.mul_start) begin
        mbusy_q <= 1'b1;
        mcnt_q  <= '0;
      end else if (mbusy_q) begin
        mcnt_q <= mcnt_q + 4'd1;
        if (mcnt_q == 4'd8) mbusy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mbusy_q) begin
      if (mcnt_q != 4'd8) prod_q <= 34'(opa) * 34'(opb);
      if (mcnt_q != 4'd0) begin
        if (!mcnt_m1[0]) hold_q <= prod_q;
        else begin
          case (mcnt_m1[2:1])
            2'd0:    det_q  <= diff;
            2'd1:    t_q[0] <= diff;
            2'd2:    t_q[1] <= diff;
            default: t_q[2] <= diff;
          endcase
        end
      end
    end
  end

  // Normalizer input: signed tangent or a stored sum
  logic signed [VEC_W-1:0] nvec [3];
  logic                    ndone, nzero;
  logic signed [TAN_W-1:0] nres [3];
  logic signed [SW:0]      ssum [3];

  for (genvar g = 0; g < 3; g++) begin : g_comp
    logic signed [SW-1:0] cur;
    assign cur     = srdata_q[g*SW +: SW];
    assign nvec[g] = cmd_i.norm_src_sum ? VEC_W'(cur)
                   : (det_q[34] ? -VEC_W'(t_q[g]) : VEC_W'(t_q[g]));
    // saturating add of the normalized tangent
    assign ssum[g] = (SW+1)'(cur) + (SW+1)'(nres[g]);
    assign swdata[g*SW +: SW] = (ssum[g] > SUM_MAX) ? SUM_MAX[SW-1:0]
                              : (ssum[g] < SUM_MIN) ? SUM_MIN[SW-1:0]
                              : ssum[g][SW-1:0];
  end

  mtacc_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.norm_start),
    .vec_i   (nvec),
    .done_o  (ndone),
    .zero_o  (nzero),
    .n_o     (nres)
  );

  // Output register
  logic ok;
  assign ok = in_range(beat_q.vertex_index) && !nzero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (cmd_i.out_load) out_valid_o <= 1'b1;
    else if (!out_stall_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_beat_o.read_index  <= beat_q.vertex_index;
      out_beat_o.tangent_x   <= ok ? nres[0] : '0;
      out_beat_o.tangent_y   <= ok ? nres[1] : '0;
      out_beat_o.tangent_z   <= ok ? nres[2] : '0;
      out_beat_o.zero_length <= !ok;
    end
  end

  // Status to the controller
  assign sts_o.op         = op_e'(beat_q.operation);
  assign sts_o.idx_ok     = in_range(beat_q.vertex_index);
  assign sts_o.corners_ok = in_range(beat_q.corner_a) && in_range(beat_q.corner_b)
                         && in_range(beat_q.corner_c);
  assign sts_o.mul_done   = mdone_q;
  assign sts_o.det_zero   = (det_q == '0);
  assign sts_o.norm_done  = ndone;
  assign sts_o.norm_zero  = nzero;
  assign sts_o.out_free   = !out_valid_o || !out_stall_i;

endmodule

[rtl/mtacc_ctrl.sv]
// Controller state machine: sequences loads, triangles and reads.
`timescale 1ns / 1ps
module mtacc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mtacc_pkg::status_t  sts_i,
  output mtacc_pkg::cmd_t     cmd_o
);
  import mtacc_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_DECODE = 14'b00000000000010,
    S_VA     = 14'b00000000000100,
    S_VB     = 14'b00000000001000,
    S_VC     = 14'b00000000010000,
    S_VL     = 14'b00000000100000,
    S_MUL    = 14'b00000001000000,
    S_NORM   = 14'b00000010000000,
    S_SRD    = 14'b00000100000000,
    S_SWR    = 14'b00001000000000,
    S_RRD    = 14'b00010000000000,
    S_RNRM   = 14'b00100000000000,
    S_RWAIT  = 14'b01000000000000,
    S_ROUT   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  sel_e   corner_q, corner_d;

  always_comb begin
    state_d  = state_q;
    corner_d = corner_q;
    cmd_o    = '0;
    cmd_o.vrd_sel  = SEL_A;
    cmd_o.vcap_sel = SEL_A;
    cmd_o.sum_sel  = corner_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.op)
          OP_LOAD: begin
            cmd_o.vtx_load = sts_i.idx_ok;
            state_d = S_IDLE;
          end
          OP_TRI:  state_d = sts_i.corners_ok ? S_VA : S_IDLE;
          OP_READ: state_d = sts_i.idx_ok ? S_RRD : S_ROUT;
          default: state_d = S_IDLE;
        endcase
      end
      // fetch three corners, one read a cycle
      S_VA: begin
        cmd_o.vrd = 1'b1;
        state_d = S_VB;
      end
      S_VB: begin
        cmd_o.vrd = 1'b1;
        cmd_o.vrd_sel = SEL_B;
        cmd_o.vcap = 1'b1;
        state_d = S_VC;
      end
      S_VC: begin
        cmd_o.vrd = 1'b1;
        cmd_o.vrd_sel = SEL_C;
        cmd_o.vcap = 1'b1;
        cmd_o.vcap_sel = SEL_B;
        state_d = S_VL;
      end
      S_VL: begin
        cmd_o.vcap = 1'b1;
        cmd_o.vcap_sel = SEL_C;
        cmd_o.mul_start = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        if (sts_i.mul_done) begin
          if (sts_i.det_zero) state_d = S_IDLE;
          else begin
            cmd_o.norm_start = 1'b1;
            state_d = S_NORM;
          end
        end
      end
      S_NORM: begin
        if (sts_i.norm_done) begin
          corner_d = SEL_A;
          state_d = sts_i.norm_zero ? S_IDLE : S_SRD;
        end
      end
      // read-modify-write each corner sum in turn
      S_SRD: begin
        cmd_o.sum_rd = 1'b1;
        state_d = S_SWR;
      end
      S_SWR: begin
        cmd_o.sum_wr = 1'b1;
        if (corner_q == SEL_C) state_d = S_IDLE;
        else begin
          corner_d = (corner_q == SEL_A) ? SEL_B : SEL_C;
          state_d = S_SRD;
        end
      end
      S_RRD: begin
        cmd_o.sum_rd = 1'b1;
        cmd_o.sum_sel = SEL_IDX;
        state_d = S_RNRM;
      end
      S_RNRM: begin
        cmd_o.sum_sel = SEL_IDX;
        cmd_o.norm_start = 1'b1;
        cmd_o.norm_src_sum = 1'b1;
        state_d = S_RWAIT;
      end
      S_RWAIT: if (sts_i.norm_done) state_d = S_ROUT;
      // wait for room in the output register
      S_ROUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      corner_q <= SEL_A;
    end else begin
      state_q  <= state_d;
      corner_q <= corner_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

[rtl/mesh_tangent_accumulator_core.sv]
// Top level of the mesh tangent accumulator.
//
//  channel | direction | handshake              | beat type
//  in      | input     | in_valid_i / in_stall_o   | mtacc_pkg::in_beat_t
//  out     | output    | out_valid_o / out_stall_i | mtacc_pkg::out_beat_t
//
// One item at a time. A triangle and a read each include a pass through the
// normalizer. The normalizer scales the vector, sums the squares, takes the
// root in 31 steps and then divides the three components in turn.
// No clearing pass: memories are undefined until loaded; reset clears control.
// A result waits in the output register under out_stall_i; new items are taken
// meanwhile, and a later read holds only until that register is free.
`timescale 1ns / 1ps
module mesh_tangent_accumulator_core #(
  parameter int unsigned VERTEX_SLOTS = 1024,
  parameter int unsigned SUM_WIDTH    = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  mtacc_pkg::in_beat_t   in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output mtacc_pkg::out_beat_t  out_beat_o
);
  import mtacc_pkg::*;

  cmd_t    cmd;
  status_t sts;

  mtacc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mtacc_datapath #(
    .VERTEX_SLOTS (VERTEX_SLOTS),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_beat_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

[rtl/mtacc_checker.sv]
// Port-level checker for the mesh tangent accumulator, bound to the top level.
`timescale 1ns / 1ps
`include "mesh_tangent_accumulator_core_macros.svh"
module mtacc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input mtacc_pkg::in_beat_t  in_beat_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input mtacc_pkg::out_beat_t out_beat_o
);
  import mtacc_pkg::*;

  // a stalled result stays offered
  `MTA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // an accepted beat keeps the block busy for the next cycle
  `MTA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // a zero-length result carries a zero tangent
  `MTA_ASSERT_IMPL(a_zero_tangent, clk_i, rst_ni, out_valid_o && out_beat_o.zero_length, (out_beat_o.tangent_x == 16'sd0) && (out_beat_o.tangent_y == 16'sd0) && (out_beat_o.tangent_z == 16'sd0))

  // every component stays within one in Q1.14
  `MTA_ASSERT_IMPL(a_unit_range, clk_i, rst_ni, out_valid_o, (out_beat_o.tangent_x <= 16'sd16384) && (out_beat_o.tangent_x >= -16'sd16384) && (out_beat_o.tangent_y <= 16'sd16384) && (out_beat_o.tangent_y >= -16'sd16384) && (out_beat_o.tangent_z <= 16'sd16384) && (out_beat_o.tangent_z >= -16'sd16384))

endmodule

bind mesh_tangent_accumulator_core mtacc_checker u_checker (.*);
